FILE: rtl/ggafs_pkg.sv
// Shared types and constants for the GGA sentence field splitter.
`timescale 1ns / 1ps

package ggafs_pkg;

  localparam int unsigned HeaderLen = 6;

  localparam logic [7:0] CharStart = 8'h24;  // '$'
  localparam logic [7:0] CharStar  = 8'h2A;  // '*'
  localparam logic [7:0] CharComma = 8'h2C;  // ','
  localparam logic [7:0] CharDot   = 8'h2E;  // '.'

  typedef enum logic [1:0] {
    MODE_WAIT,
    MODE_HEADER,
    MODE_DATA
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_CHAR,
    EV_FIELD_END,
    EV_DONE,
    EV_OVERFLOW
  } event_e;

  typedef struct packed {
    event_e     event_kind;
    logic [3:0] field_index;
    logic [3:0] char_pos;
    logic [7:0] char_value;
  } result_t;

  // Expected header byte "GPGGA," at a given match position.
  function automatic logic [7:0] header_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h47;  // 'G'
      3'd1:    ch = 8'h50;  // 'P'
      3'd2:    ch = 8'h47;  // 'G'
      3'd3:    ch = 8'h47;  // 'G'
      3'd4:    ch = 8'h41;  // 'A'
      3'd5:    ch = 8'h2C;  // ','
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Clamp a counter value to the 4-bit report range.
  function automatic logic [3:0] sat15(input logic [7:0] v);
    return (v > 8'd15) ? 4'd15 : v[3:0];
  endfunction

endpackage

FILE: rtl/ggafs_parser.sv
// Parser state and per-byte decode: header match, field and position counters.
`timescale 1ns / 1ps

module ggafs_parser #(
  parameter int unsigned NUM_FIELDS = 16,
  parameter int unsigned FIELD_LEN  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  output ggafs_pkg::result_t result_o
);
  import ggafs_pkg::*;

  localparam int unsigned FW = $clog2(NUM_FIELDS + 1);
  localparam int unsigned PW = $clog2(FIELD_LEN + 1);

  mode_e         mode_q, mode_d;
  logic [2:0]    hpos_q, hpos_d;
  logic [FW-1:0] fcnt_q, fcnt_d;
  logic [PW-1:0] pcnt_q, pcnt_d;

  logic fields_full, field_long, hdr_hit;

  assign fields_full = (fcnt_q >= FW'(NUM_FIELDS));
  assign field_long  = (pcnt_q >= PW'(FIELD_LEN));
  assign hdr_hit     = (byte_i == header_char(hpos_q));

  // Next state
  always_comb begin
    mode_d = mode_q;
    hpos_d = hpos_q;
    fcnt_d = fcnt_q;
    pcnt_d = pcnt_q;
    case (mode_q)
      MODE_HEADER: begin
        if (hdr_hit) begin
          if (hpos_q == 3'(HeaderLen - 1)) begin
            mode_d = MODE_DATA;
            hpos_d = '0;
            fcnt_d = '0;
            pcnt_d = '0;
          end else begin
            hpos_d = hpos_q + 3'd1;
          end
        end else begin
          mode_d = MODE_WAIT;
          hpos_d = '0;
        end
      end
      MODE_DATA: begin
        if (byte_i == CharDot) begin
          mode_d = MODE_DATA;
        end else if (byte_i == CharStar) begin
          mode_d = MODE_WAIT;
          hpos_d = '0;
          fcnt_d = '0;
          pcnt_d = '0;
        end else if (fields_full) begin
          mode_d = MODE_DATA;
        end else if (byte_i == CharComma) begin
          fcnt_d = fcnt_q + FW'(1);
          pcnt_d = '0;
        end else if (!field_long) begin
          pcnt_d = pcnt_q + PW'(1);
        end
      end
      default: begin
        if (byte_i == CharStart) begin
          mode_d = MODE_HEADER;
          hpos_d = '0;
        end else begin
          mode_d = MODE_WAIT;
        end
      end
    endcase
  end

  // Result
  always_comb begin
    result_o             = '0;
    result_o.event_kind  = EV_NONE;
    case (mode_q)
      MODE_DATA: begin
        if (byte_i == CharDot) begin
          result_o.event_kind = EV_NONE;
        end else if (byte_i == CharStar) begin
          result_o.event_kind = EV_DONE;
        end else if (fields_full) begin
          result_o.event_kind = EV_OVERFLOW;
        end else if (byte_i == CharComma) begin
          result_o.event_kind = EV_FIELD_END;
        end else if (field_long) begin
          result_o.event_kind = EV_OVERFLOW;
        end else begin
          result_o.event_kind = EV_CHAR;
          result_o.char_value = byte_i;
        end
        if (result_o.event_kind != EV_NONE) begin
          result_o.field_index = sat15(8'(fcnt_q));
          result_o.char_pos    = sat15(8'(pcnt_q));
        end
      end
      default: begin
        result_o.event_kind = EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_WAIT;
      hpos_q <= '0;
      fcnt_q <= '0;
      pcnt_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      hpos_q <= hpos_d;
      fcnt_q <= fcnt_d;
      pcnt_q <= pcnt_d;
    end
  end

endmodule

FILE: rtl/gga_sentence_field_splitter_unit.sv
// Top level: input register, parser, result register with valid/ready on both sides.
//
//   channel   signals                                   direction
//   input     in_valid_i, in_ready_o, rx_byte_i         request in
//   result    out_valid_o, out_ready_i, event_kind_o,   request out
//             field_index_o, char_pos_o, char_value_o
//
// Each received byte yields exactly one result request: it is held in the input
// register, decoded, then loaded into the result register.
// One byte per cycle is sustained while the result side keeps taking requests.
// Reset puts the parser back to waiting for '$' and empties both registers.
// A stalled result holds the pipe; the input register still takes one byte.
`timescale 1ns / 1ps

module gga_sentence_field_splitter_unit #(
  parameter int unsigned NUM_FIELDS = 16,
  parameter int unsigned FIELD_LEN  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] event_kind_o,
  output logic [3:0] field_index_o,
  output logic [3:0] char_pos_o,
  output logic [7:0] char_value_o
);
  import ggafs_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  result_t    res_q, res_d;
  logic       out_free, advance;

  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || advance;

  ggafs_parser #(
    .NUM_FIELDS(NUM_FIELDS),
    .FIELD_LEN (FIELD_LEN)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (in_byte_q),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Payload registers: load on request transfer only
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign event_kind_o  = res_q.event_kind;
  assign field_index_o = res_q.field_index;
  assign char_pos_o    = res_q.char_pos;
  assign char_value_o  = res_q.char_value;

endmodule

FILE: verif/gga_sentence_field_splitter_unit_test.sv
// Self-checking bench for the GGA field splitter: sentence stimulus, field tracker, result check.
`timescale 1ns / 1ps

module gga_sentence_field_splitter_unit_test;
  import ggafs_pkg::*;

  localparam int unsigned NumFields = 16;
  localparam int unsigned FieldLen  = 16;
  localparam logic [7:0] GgaText [HeaderLen] = '{8'h47, 8'h50, 8'h47, 8'h47, 8'h41, 8'h2C};

  // Tracks the parser state and holds the result each accepted byte should give.
  class gga_field_tracker;
    mode_e       mode;
    int unsigned hdr_pos;
    int unsigned field_cnt;
    int unsigned pos_cnt;
    result_t     expected_q[$];
    int unsigned mismatches;

    function new();
      mode       = MODE_WAIT;
      hdr_pos    = 0;
      field_cnt  = 0;
      pos_cnt    = 0;
      mismatches = 0;
    endfunction

    function logic [3:0] clamp4(input int unsigned v);
      return (v > 15) ? 4'd15 : v[3:0];
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      mismatches++;
    endtask

    function void note_request(input logic [7:0] b);
      result_t r;
      r = '0;
      case (mode)
        MODE_HEADER: begin
          if (b == GgaText[hdr_pos]) begin
            hdr_pos++;
            if (hdr_pos == HeaderLen) begin
              mode      = MODE_DATA;
              hdr_pos   = 0;
              field_cnt = 0;
              pos_cnt   = 0;
            end
          end else begin
            // mismatch eats the byte, '$' included
            mode    = MODE_WAIT;
            hdr_pos = 0;
          end
        end
        MODE_DATA: begin
          if (b == CharDot) begin
            r = '0;
          end else if (b == CharStar) begin
            r.event_kind  = EV_DONE;
            r.field_index = clamp4(field_cnt);
            r.char_pos    = clamp4(pos_cnt);
            field_cnt     = 0;
            pos_cnt       = 0;
            hdr_pos       = 0;
            mode          = MODE_WAIT;
          end else if (field_cnt >= NumFields) begin
            r.event_kind  = EV_OVERFLOW;
            r.field_index = clamp4(field_cnt);
            r.char_pos    = clamp4(pos_cnt);
          end else if (b == CharComma) begin
            r.event_kind  = EV_FIELD_END;
            r.field_index = clamp4(field_cnt);
            r.char_pos    = clamp4(pos_cnt);
            field_cnt++;
            pos_cnt       = 0;
          end else if (pos_cnt >= FieldLen) begin
            r.event_kind  = EV_OVERFLOW;
            r.field_index = clamp4(field_cnt);
            r.char_pos    = clamp4(pos_cnt);
          end else begin
            r.event_kind  = EV_CHAR;
            r.field_index = clamp4(field_cnt);
            r.char_pos    = clamp4(pos_cnt);
            r.char_value  = b;
            pos_cnt++;
          end
        end
        default: begin
          if (b == CharStart) begin
            mode    = MODE_HEADER;
            hdr_pos = 0;
          end else begin
            mode = MODE_WAIT;
          end
        end
      endcase
      expected_q.push_back(r);
    endfunction

    task check_result(input logic [2:0] kind, input logic [3:0] fidx,
                      input logic [3:0] pos, input logic [7:0] val);
      result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, kind", int'(kind), -1);
      end else begin
        e = expected_q.pop_front();
        if (kind != e.event_kind) report_mismatch("event_kind", int'(kind), int'(e.event_kind));
        if (fidx != e.field_index) begin
          report_mismatch("field_index", int'(fidx), int'(e.field_index));
        end
        if (pos != e.char_pos) report_mismatch("char_pos", int'(pos), int'(e.char_pos));
        if (val != e.char_value) report_mismatch("char_value", int'(val), int'(e.char_value));
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] event_kind_o;
  logic [3:0] field_index_o;
  logic [3:0] char_pos_o;
  logic [7:0] char_value_o;

  gga_field_tracker tracker;
  int unsigned      idle_pct;
  int unsigned      stall_pct;
  int unsigned      bytes_sent;

  gga_sentence_field_splitter_unit #(
    .NUM_FIELDS(NumFields),
    .FIELD_LEN (FieldLen)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_kind_o (event_kind_o),
    .field_index_o(field_index_o),
    .char_pos_o   (char_pos_o),
    .char_value_o (char_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

  // Offer one byte; lower valid only when a gap is chosen, so valid never dips between requests.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_request(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] field_char();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return 8'($urandom_range(8'h30, 8'h39));
    if (pick < 60) return 8'($urandom_range(8'h41, 8'h5A));
    if (pick < 75) return CharDot;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed sentences with random content; the rest broken headers and line noise.
  task automatic send_random_burst();
    logic [7:0]  burst_q[$];
    int unsigned kind;
    int unsigned n_fields;
    int unsigned len;
    int unsigned long_idx;
    int unsigned cut;
    kind = $urandom_range(99);
    if (kind < 70) begin
      burst_q.push_back(CharStart);
      foreach (GgaText[i]) burst_q.push_back(GgaText[i]);
      if ($urandom_range(9) == 0) begin
        // push up to and past the field limit with short fields
        n_fields = $urandom_range(14, 19);
        for (int f = 0; f < n_fields; f++) begin
          len = $urandom_range(0, 2);
          for (int c = 0; c < len; c++) burst_q.push_back(field_char());
          burst_q.push_back(CharComma);
        end
      end else begin
        n_fields = $urandom_range(1, 5);
        long_idx = ($urandom_range(7) == 0) ? $urandom_range(0, n_fields - 1) : n_fields;
        for (int f = 0; f < n_fields; f++) begin
          len = (f == long_idx) ? $urandom_range(13, 19) : $urandom_range(0, 5);
          for (int c = 0; c < len; c++) burst_q.push_back(field_char());
          if (f != n_fields - 1) burst_q.push_back(CharComma);
        end
      end
      if ($urandom_range(9) != 0) begin
        burst_q.push_back(CharStar);
        burst_q.push_back(8'($urandom_range(8'h30, 8'h46)));
        burst_q.push_back(8'($urandom_range(8'h30, 8'h46)));
        burst_q.push_back(8'h0D);
        burst_q.push_back(8'h0A);
      end
    end else if (kind < 85) begin
      burst_q.push_back(CharStart);
      cut = $urandom_range(0, HeaderLen - 1);
      for (int i = 0; i < cut; i++) burst_q.push_back(GgaText[i]);
      burst_q.push_back(($urandom_range(3) == 0) ? CharStart : 8'($urandom_range(0, 255)));
    end else begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) burst_q.push_back(8'($urandom_range(0, 255)));
    end
    foreach (burst_q[i]) send_byte(burst_q[i]);
  endtask

  // Result side: take or stall each cycle, check what is taken.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        tracker.check_result(event_kind_o, field_index_o, char_pos_o, char_value_o);
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    logic [7:0]  directed_q[$];
    int unsigned idle_plan[4];
    int unsigned stall_plan[4];
    tracker    = new();
    idle_plan  = '{0, 84, 0, 36};
    stall_plan = '{0, 0, 84, 36};
    idle_pct   = 0;
    stall_pct  = 0;
    bytes_sent = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    rx_byte_i  <= 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short sentence with extreme bytes, a dot, an empty field, then broken headers.
    directed_q = '{8'hFF, CharStart, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41, 8'h2C,
                   8'hFF, 8'h00, CharDot, CharComma, CharComma, 8'h41, CharStar,
                   CharStart, 8'h47, 8'h58,
                   CharStart, CharStart, 8'h47,
                   CharStart, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41, 8'h2E};
    foreach (directed_q[i]) send_byte(directed_q[i]);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      while (bytes_sent < (p + 1) * 112) send_random_burst();
    end
    in_valid_i <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
